/* rtl/swg_pkg.sv */
// Shared types, constants and the quarter-wave sine table for the strain
// waveform generator. No dependencies; every other file imports this package.

package swg_pkg;

    // Quarter-wave sine table geometry.
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_N          = 1 << SINE_TABLE_BITS;

    // Fixed-point constants.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [33:0] RAMP_LIMIT  = 34'h2_0000_0000;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FREQUENCY     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_TIME    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRAIN_OFFSET = 3'd4;

    typedef enum logic [1:0] {
        WAVE_CONST    = 2'd0,
        WAVE_SINE     = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_RAMP     = 2'd3
    } wave_mode_t;

    // Request leaving the phase stages: magnitude of the time difference,
    // its sign, the low bits of frequency * |dt| and |amplitude| * frequency.
    typedef struct packed {
        logic        valid;
        logic [31:0] udt;
        logic        dt_neg;
        logic [39:0] prod_lo;
        logic [63:0] m1;
    } swg_phase_t;

    // Request leaving the shape stages: scaled sine or triangle value and
    // the clamped ramp magnitude with its sign.
    typedef struct packed {
        logic               valid;
        logic signed [33:0] wave_v;
        logic [33:0]        ramp_mag;
        logic               ramp_neg;
    } swg_shape_t;

    typedef logic [30:0] sine_lut_t [SINE_N];

    // Entry k holds sin(pi/2*(k+0.5)/N) in Q1.30, built from an 8-term Taylor
    // series with truncating steps and clamped to [0, 1.0].
    function automatic sine_lut_t build_sine_lut();
        sine_lut_t          lut;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int k = 0; k < SINE_N; k++) begin
            x    = (64'(2 * k + 1) * HALF_PI_Q30) >> (SINE_TABLE_BITS + 1);
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - signed'(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + signed'(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - signed'(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + signed'(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - signed'(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + signed'(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - signed'(term);
            if (sum < 0) begin
                sum = 64'sd0;
            end
            if (sum > signed'(ONE_Q30)) begin
                sum = signed'(ONE_Q30);
            end
            lut[k] = sum[30:0];
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

/* rtl/strain_waveform_generator_unit.sv */
// Strain waveform generator: five-stage pipeline, one time sample in and one
// strain result out per cycle. Throughput is one request per cycle, set by
// the fully pipelined multipliers and the registered sine table read.
// busy stays low since the receiver cannot stall. Reset clears all pipeline
// valid bits and sets every configuration register to zero.

module strain_waveform_generator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [31:0]                     time_now,
    output logic                            done,
    output logic signed [31:0]              strain_value,
    output logic                            saturated,
    input  logic                            wr_en,
    input  logic [swg_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [swg_pkg::CFG_DATA_W-1:0]  wr_data
);
    import swg_pkg::*;

    wave_mode_t         wave_mode_reg;
    logic signed [31:0] amplitude_reg;
    logic [31:0]        frequency_reg;
    logic [31:0]        start_time_reg;
    logic signed [31:0] strain_offset_reg;

    logic               accept;
    swg_phase_t         phase_bus;
    swg_shape_t         shape_bus;

    // Configuration registers; indexes past the last register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg     <= WAVE_CONST;
            amplitude_reg     <= 32'sd0;
            frequency_reg     <= 32'd0;
            start_time_reg    <= 32'd0;
            strain_offset_reg <= 32'sd0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_WAVE_MODE:     wave_mode_reg     <= wave_mode_t'(wr_data[1:0]);
                CFG_AMPLITUDE:     amplitude_reg     <= signed'(wr_data[31:0]);
                CFG_FREQUENCY:     frequency_reg     <= wr_data[31:0];
                CFG_START_TIME:    start_time_reg    <= wr_data[31:0];
                CFG_STRAIN_OFFSET: strain_offset_reg <= signed'(wr_data[31:0]);
                default:           ;
            endcase
        end
    end

    // A new request enters the pipeline on every cycle that start is high.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    swg_phase u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .time_now   (time_now),
        .start_time (start_time_reg),
        .frequency  (frequency_reg),
        .amplitude  (amplitude_reg),
        .phase_out  (phase_bus)
    );

    swg_shape u_shape (
        .clk        (clk),
        .rst_n      (rst_n),
        .phase_in   (phase_bus),
        .wave_mode  (wave_mode_reg),
        .amplitude  (amplitude_reg),
        .shape_out  (shape_bus)
    );

    swg_output u_output (
        .clk           (clk),
        .rst_n         (rst_n),
        .shape_in      (shape_bus),
        .wave_mode     (wave_mode_reg),
        .strain_offset (strain_offset_reg),
        .done          (done),
        .strain_value  (strain_value),
        .saturated     (saturated)
    );

endmodule

/* rtl/swg_phase.sv */
// Phase front end: time difference against the start time, then the
// frequency products. Depends on swg_pkg.

module swg_phase (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [31:0]        time_now,
    input  logic [31:0]        start_time,
    input  logic [31:0]        frequency,
    input  logic signed [31:0] amplitude,
    output swg_pkg::swg_phase_t phase_out
);
    import swg_pkg::*;

    logic [32:0] dt;
    logic [32:0] dt_abs;
    logic [31:0] amp_abs;
    logic [63:0] prod;
    logic [63:0] m1;

    logic        s1_valid_reg;
    logic [31:0] s1_udt_reg;
    logic        s1_dt_neg_reg;
    logic [31:0] s1_amp_abs_reg;

    logic        s2_valid_reg;
    logic [31:0] s2_udt_reg;
    logic        s2_dt_neg_reg;
    logic [39:0] s2_prod_lo_reg;
    logic [63:0] s2_m1_reg;

    // Stage 1: exact signed difference, kept as magnitude and sign.
    always_comb
    begin
        dt      = {1'b0, time_now} - {1'b0, start_time};
        dt_abs  = dt[32] ? (33'd0 - dt) : dt;
        amp_abs = amplitude[31] ? (32'd0 - unsigned'(amplitude)) : unsigned'(amplitude);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_udt_reg     <= dt_abs[31:0];
        s1_dt_neg_reg  <= dt[32];
        s1_amp_abs_reg <= amp_abs;
    end

    // Stage 2: frequency times |dt| for the phase, |amplitude| times
    // frequency for the ramp.
    always_comb
    begin
        prod = {32'd0, s1_udt_reg} * {32'd0, frequency};
        m1   = {32'd0, s1_amp_abs_reg} * {32'd0, frequency};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_udt_reg     <= s1_udt_reg;
        s2_dt_neg_reg  <= s1_dt_neg_reg;
        s2_prod_lo_reg <= prod[39:0];
        s2_m1_reg      <= m1;
    end

    // Pack the stage 2 registers into the request handed downstream.
    always_comb
    begin
        phase_out.valid   = s2_valid_reg;
        phase_out.udt     = s2_udt_reg;
        phase_out.dt_neg  = s2_dt_neg_reg;
        phase_out.prod_lo = s2_prod_lo_reg;
        phase_out.m1      = s2_m1_reg;
    end

endmodule

/* rtl/swg_shape.sv */
// Waveform shaping: phase fraction, sine table and triangle fold, then the
// amplitude multiply and the ramp product sum. Depends on swg_pkg.

module swg_shape (
    input  logic                clk,
    input  logic                rst_n,
    input  swg_pkg::swg_phase_t phase_in,
    input  swg_pkg::wave_mode_t wave_mode,
    input  logic signed [31:0]  amplitude,
    output swg_pkg::swg_shape_t shape_out
);
    import swg_pkg::*;

    logic [39:0]                p40;
    logic [31:0]                phase;
    logic [SINE_TABLE_BITS-1:0] sine_idx;
    logic [31:0]                tri_q;
    logic [31:0]                tri_mag;
    logic [63:0]                plo;
    logic [63:0]                phi;

    logic                       s3_valid_reg;
    logic                       s3_dt_neg_reg;
    logic [30:0]                s3_sine_mag_reg;
    logic                       s3_sine_neg_reg;
    logic signed [31:0]         s3_tri_d_reg;
    logic [63:0]                s3_plo_reg;
    logic [63:0]                s3_phi_reg;

    logic signed [31:0]         sine_s;
    logic signed [31:0]         factor;
    logic signed [63:0]         wave_prod;
    logic [63:0]                ramp_sum;
    logic [55:0]                ramp_shift;
    logic [33:0]                ramp_mag;

    logic                       s4_valid_reg;
    logic signed [33:0]         s4_wave_v_reg;
    logic [33:0]                s4_ramp_mag_reg;
    logic                       s4_ramp_neg_reg;

    // Stage 3: phase fraction in Q.32, table index with quadrant mirror,
    // triangle fold, and the two halves of the ramp product.
    always_comb
    begin
        p40      = phase_in.dt_neg ? (40'd0 - phase_in.prod_lo) : phase_in.prod_lo;
        phase    = p40[39:8];
        sine_idx = phase[29 -: SINE_TABLE_BITS];
        if (phase[30])
        begin
            sine_idx = ~sine_idx;
        end
        tri_q   = phase + 32'h4000_0000;
        tri_mag = tri_q[31] ? (32'd0 - tri_q) : tri_q;
        plo     = {32'd0, phase_in.m1[31:0]} * {32'd0, phase_in.udt};
        phi     = {32'd0, phase_in.m1[63:32]} * {32'd0, phase_in.udt};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= phase_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_sine_mag_reg <= SINE_LUT[sine_idx];
        s3_sine_neg_reg <= phase[31];
        s3_tri_d_reg    <= signed'(tri_mag - 32'h4000_0000);
        s3_plo_reg      <= plo;
        s3_phi_reg      <= phi;
        s3_dt_neg_reg   <= phase_in.dt_neg;
    end

    // Stage 4: signed sine or triangle times amplitude, ramp sum and clamp.
    always_comb
    begin
        sine_s = s3_sine_neg_reg ? (32'sd0 - signed'({1'b0, s3_sine_mag_reg}))
                                 : signed'({1'b0, s3_sine_mag_reg});
        factor     = (wave_mode == WAVE_SINE) ? sine_s : s3_tri_d_reg;
        wave_prod  = amplitude * factor;
        ramp_sum   = s3_phi_reg + {32'd0, s3_plo_reg[63:32]};
        ramp_shift = ramp_sum[63:8];
        ramp_mag   = (ramp_shift > {22'd0, RAMP_LIMIT}) ? RAMP_LIMIT : ramp_shift[33:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_wave_v_reg   <= wave_prod[63:30];
        s4_ramp_mag_reg <= ramp_mag;
        s4_ramp_neg_reg <= amplitude[31] ^ s3_dt_neg_reg;
    end

    // Pack the stage 4 registers into the request handed downstream.
    always_comb
    begin
        shape_out.valid    = s4_valid_reg;
        shape_out.wave_v   = s4_wave_v_reg;
        shape_out.ramp_mag = s4_ramp_mag_reg;
        shape_out.ramp_neg = s4_ramp_neg_reg;
    end

endmodule

/* rtl/swg_output.sv */
// Output stage: waveform select, offset add and saturation into the result
// registers. Depends on swg_pkg.

module swg_output (
    input  logic                clk,
    input  logic                rst_n,
    input  swg_pkg::swg_shape_t shape_in,
    input  swg_pkg::wave_mode_t wave_mode,
    input  logic signed [31:0]  strain_offset,
    output logic                done,
    output logic signed [31:0]  strain_value,
    output logic                saturated
);
    import swg_pkg::*;

    logic signed [34:0] ramp_v;
    logic signed [34:0] v;
    logic signed [35:0] r;
    logic signed [31:0] r_sat;
    logic               sat;

    logic               done_reg;
    logic signed [31:0] strain_value_reg;
    logic               saturated_reg;

    // Pick the waveform value, add the offset and clip to 32 bits.
    always_comb
    begin
        ramp_v = shape_in.ramp_neg ? (35'sd0 - signed'({1'b0, shape_in.ramp_mag}))
                                   : signed'({1'b0, shape_in.ramp_mag});
        unique case (wave_mode)
            WAVE_CONST:    v = 35'sd0;
            WAVE_SINE:     v = 35'(shape_in.wave_v);
            WAVE_TRIANGLE: v = 35'(shape_in.wave_v);
            WAVE_RAMP:     v = ramp_v;
            default:       v = 35'sd0;
        endcase
        r = 36'(v) + 36'(strain_offset);
        priority if (r > 36'sh0_7FFF_FFFF)
        begin
            r_sat = 32'sh7FFF_FFFF;
            sat   = 1'b1;
        end
        else if (r < -36'sh0_8000_0000)
        begin
            r_sat = 32'sh8000_0000;
            sat   = 1'b1;
        end
        else
        begin
            r_sat = r[31:0];
            sat   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= shape_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        strain_value_reg <= r_sat;
        saturated_reg    <= sat;
    end

    assign done         = done_reg;
    assign strain_value = strain_value_reg;
    assign saturated    = saturated_reg;

endmodule

/* bench/swg_strain_checker.sv */
`timescale 1ns / 100ps
// Checker for the strain waveform generator: mirrors the register writes,
// predicts each strain result and compares it with what the unit returns.
// Depends on swg_pkg for the register indexes, the wave mode type and widths.

module swg_strain_checker
    import swg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [31:0]            time_now,
    input  logic                   done,
    input  logic signed [31:0]     strain_value,
    input  logic                   saturated,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output int                     fail_count,
    output int                     outstanding
);

    localparam longint ONE_Q30_S   = 64'sd1073741824;
    localparam longint STRAIN_MAX  = 64'sd2147483647;
    localparam longint STRAIN_MIN  = -64'sd2147483648;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] RAMP_CLAMP  = 64'h2_0000_0000;

    typedef struct {
        logic [31:0] value;
        logic        sat;
    } strain_result_t;

    // Mirrored configuration registers.
    wave_mode_t         mode_r;
    logic signed [31:0] amp_r;
    logic [31:0]        freq_r;
    logic [31:0]        t0_r;
    logic signed [31:0] ofs_r;

    logic [30:0]    quarter_sine_tab [SINE_N];
    strain_result_t strain_expected_q [$];

    // One quarter-wave entry: sin(pi/2*(k+0.5)/N) in Q1.30 from a truncated
    // Taylor series, clamped to [0, 1.0].
    function automatic logic [30:0] quarter_sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        begin
            x    = (64'(2 * k + 1) * PI_HALF_Q30) >> (SINE_TABLE_BITS + 1);
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            if (acc > ONE_Q30_S)
                acc = ONE_Q30_S;
            return acc[30:0];
        end
    endfunction

    initial
    begin
        for (int k = 0; k < SINE_N; k++)
            quarter_sine_tab[k] = quarter_sine_entry(k);
    end

    // Strain for one time sample under the mirrored configuration.
    function automatic strain_result_t compute_strain(input logic [31:0] t);
        strain_result_t res;
        longint         dt;
        longint         v;
        longint         r;
        longint         amp_s;
        longint         s;
        logic           dt_neg;
        logic           a_neg;
        logic [63:0]    udt;
        logic [63:0]    prod;
        logic [63:0]    ua;
        logic [63:0]    m1;
        logic [63:0]    plo;
        logic [63:0]    phi;
        logic [63:0]    mag;
        logic [31:0]    phase;
        logic [31:0]    qu;
        logic [31:0]    tri_mag;
        logic [1:0]     quad;
        int unsigned    k;
        begin
            dt     = longint'({32'd0, t}) - longint'({32'd0, t0_r});
            dt_neg = dt < 0;
            udt    = dt_neg ? 64'(-dt) : 64'(dt);
            prod   = {32'd0, freq_r} * udt;
            if (dt_neg)
                prod = -prod;
            phase = prod[39:8];
            amp_s = amp_r;
            v     = 0;

            case (mode_r)
                WAVE_SINE:
                begin
                    quad = phase[31:30];
                    k    = (phase >> (30 - SINE_TABLE_BITS)) & (SINE_N - 1);
                    if (quad[0])
                        k = SINE_N - 1 - k;
                    s = longint'({33'd0, quarter_sine_tab[k]});
                    if (quad[1])
                        s = -s;
                    v = (amp_s * s) >>> 30;
                end
                WAVE_TRIANGLE:
                begin
                    // Phase plus a quarter cycle, folded to its magnitude.
                    qu      = phase + 32'h4000_0000;
                    tri_mag = qu[31] ? -qu : qu;
                    v = (amp_s * (longint'({32'd0, tri_mag}) - ONE_Q30_S)) >>> 30;
                end
                WAVE_RAMP:
                begin
                    // Exact magnitude in split products, sign applied last.
                    a_neg = amp_r[31];
                    ua    = a_neg ? 64'(-amp_s) : 64'(amp_s);
                    m1    = ua * {32'd0, freq_r};
                    plo   = {32'd0, m1[31:0]} * udt;
                    phi   = {32'd0, m1[63:32]} * udt;
                    mag   = (phi + (plo >> 32)) >> 8;
                    if (mag > RAMP_CLAMP)
                        mag = RAMP_CLAMP;
                    v = (a_neg != dt_neg) ? -longint'(mag) : longint'(mag);
                end
                default:
                    v = 0;
            endcase

            r       = v + longint'(ofs_r);
            res.sat = 1'b0;
            if (r > STRAIN_MAX)
            begin
                r       = STRAIN_MAX;
                res.sat = 1'b1;
            end
            else if (r < STRAIN_MIN)
            begin
                r       = STRAIN_MIN;
                res.sat = 1'b1;
            end
            res.value = r[31:0];
            return res;
        end
    endfunction

    // Register mirror, result comparison and request bookkeeping.
    always @(posedge clk or negedge rst_n)
    begin
        strain_result_t want;
        if (!rst_n)
        begin
            mode_r      = WAVE_CONST;
            amp_r       = '0;
            freq_r      = '0;
            t0_r        = '0;
            ofs_r       = '0;
            strain_expected_q.delete();
            outstanding = 0;
            fail_count  = 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    CFG_WAVE_MODE:     mode_r = wave_mode_t'(wr_data[1:0]);
                    CFG_AMPLITUDE:     amp_r  = wr_data;
                    CFG_FREQUENCY:     freq_r = wr_data;
                    CFG_START_TIME:    t0_r   = wr_data;
                    CFG_STRAIN_OFFSET: ofs_r  = wr_data;
                    default:           ;
                endcase
            end

            if (done)
            begin
                if (strain_expected_q.size() == 0)
                begin
                    $display("%0t: result with no request pending: strain %h sat %b",
                             $time, strain_value, saturated);
                    fail_count++;
                end
                else
                begin
                    want = strain_expected_q.pop_front();
                    if (strain_value !== want.value)
                    begin
                        $display("%0t: strain_value expected %h got %h",
                                 $time, want.value, strain_value);
                        fail_count++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $display("%0t: saturated expected %b got %b",
                                 $time, want.sat, saturated);
                        fail_count++;
                    end
                end
            end

            if (start && !busy)
                strain_expected_q.push_back(compute_strain(time_now));

            outstanding = strain_expected_q.size();
        end
    end

endmodule

/* bench/tb_strain_waveform_generator_unit.sv */
`timescale 1ns / 100ps
// Top of the strain waveform generator bench: clock, reset, register setup
// and time-sample stimulus. Depends on swg_pkg, the unit and swg_strain_checker.

module tb_strain_waveform_generator_unit;

    import swg_pkg::*;

    localparam int PIPE_LATENCY   = 5;
    localparam int PHASE_COUNT    = 16;
    localparam int PHASE_REQUESTS = 118;

    // Indexes past the last register; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [31:0]            time_now;
    logic                   done;
    logic signed [31:0]     strain_value;
    logic                   saturated;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;
    int                     fail_count;
    int                     outstanding;
    int                     idle_pct;
    logic [31:0]            t0_cur;

    strain_waveform_generator_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .time_now     (time_now),
        .done         (done),
        .strain_value (strain_value),
        .saturated    (saturated),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    swg_strain_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .time_now     (time_now),
        .done         (done),
        .strain_value (strain_value),
        .saturated    (saturated),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the unit hangs.
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // Present one time sample, with random idle cycles ahead of it.
    task automatic send_sample(input logic [31:0] t);
        begin
            while ($urandom_range(99, 0) < idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            start    <= 1'b1;
            time_now <= t;
            do
                @(posedge clk);
            while (busy);
        end
    endtask

    // Stop issuing and wait until every pending request has returned.
    task automatic wait_drained();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (outstanding != 0)
                @(posedge clk);
            repeat (PIPE_LATENCY + 2) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        begin
            wr_en    <= 1'b1;
            wr_index <= idx;
            wr_data  <= data;
            @(posedge clk);
        end
    endtask

    // Reprogram every register once the unit is idle; a spare index is hit too.
    task automatic program_regs(input logic [31:0] mode_word, input logic [31:0] amp,
                                input logic [31:0] freq, input logic [31:0] t0,
                                input logic [31:0] offs);
        begin
            wait_drained();
            write_reg(CFG_WAVE_MODE, mode_word);
            write_reg(CFG_AMPLITUDE, amp);
            write_reg(CFG_FREQUENCY, freq);
            write_reg(CFG_START_TIME, t0);
            write_reg(CFG_STRAIN_OFFSET, offs);
            write_reg(CFG_INDEX_W'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)), $urandom);
            wr_en  <= 1'b0;
            t0_cur = t0;
        end
    endtask

    // Register value biased toward the extremes and toward small magnitudes.
    function automatic logic [31:0] pick_word();
        begin
            case ($urandom_range(7, 0))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h8000_0000;
                3:       return 32'h7FFF_FFFF;
                4:       return 32'h0100_0000;
                5:       return $urandom_range(32'h00FF_FFFF, 0);
                6:       return -$urandom_range(32'h00FF_FFFF, 0);
                default: return $urandom;
            endcase
        end
    endfunction

    // Time sample: mostly random, some close to the start time, some extremes.
    function automatic logic [31:0] pick_time();
        begin
            case ($urandom_range(5, 0))
                3:       return t0_cur + 32'($urandom_range(32'h0003_FFFF, 0)) - 32'h0002_0000;
                4:       return $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
                5:       return t0_cur + 32'($urandom_range(32'hFF, 0) << 12);
                default: return $urandom;
            endcase
        end
    endfunction

    // Stimulus: directed cases first, then randomly configured phases.
    initial
    begin
        logic [31:0] mode_word;
        rst_n    = 1'b0;
        start    = 1'b0;
        time_now = '0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        idle_pct = 0;
        t0_cur   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at their reset values.
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);

        // Sine with one period per 0x10000 time units: quadrant boundaries and a wrap.
        program_regs(32'(WAVE_SINE), 32'h7FFF_FFFF, 32'h0100_0000, 32'h0, 32'h0);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_4000);
        send_sample(32'h0000_8000);
        send_sample(32'h0000_C000);
        send_sample(32'h0000_FFFF);
        send_sample(32'h0002_0000);

        // Triangle with full-scale offset, including times before the start.
        program_regs(32'(WAVE_TRIANGLE), 32'h0100_0000, 32'h0100_0000, 32'h0000_8000,
                     32'h7FFF_FFFF);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_8000);
        send_sample(32'h0000_C000);
        send_sample(32'h0001_0000);
        send_sample(32'hFFFF_FFFF);

        // Huge ramp in both directions.
        program_regs(32'(WAVE_RAMP), 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0000);
        program_regs(32'(WAVE_RAMP), 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'h8000_0000);
        send_sample(32'h0000_0000);

        // Constant mode written with stray upper bits in the mode word.
        program_regs(32'hFFFF_FFFC, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678,
                     32'h8000_0000);
        send_sample($urandom);
        send_sample(32'hFFFF_FFFF);

        // Random phases, cycling through every wave mode and idle pattern.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            mode_word = {$urandom} & ~32'h3;
            mode_word = mode_word | 32'(ph % 4);
            program_regs(mode_word, pick_word(), pick_word(), pick_word(), pick_word());
            case ((ph / 4) % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 81;
                2:       idle_pct = 19;
                default: idle_pct = (ph % 2 == 0) ? 81 : 0;
            endcase
            for (int i = 0; i < PHASE_REQUESTS; i++)
                send_sample(pick_time());
        end

        wait_drained();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
